>>> design/ibfr_pkg.sv
// ----------------------------------------------------------------------------
// ibfr_pkg
// Shared types and constants of the IMU BCD frame receiver: the classified
// byte item that travels from the front end to the decode back end.
// ----------------------------------------------------------------------------
package ibfr_pkg;

   // Decoded values per frame and their widths
   localparam int NUM_FIELDS = 9;
   localparam int FIELD_W    = 4;
   localparam int MAG_W      = 18;
   localparam int VAL_W      = 19;
   localparam int RSP_W      = 176;

   // What the back end does with a stored byte
   typedef enum logic [1:0] {
      KIND_SKIP = 2'd0,
      KIND_B0   = 2'd1,
      KIND_B1   = 2'd2,
      KIND_B2   = 2'd3
   } kind_type;

   // One classified byte
   typedef struct packed {
      logic [7:0]         data;
      kind_type           kind;
      logic [FIELD_W-1:0] field;
      logic               last;
   } item_type;

endpackage

>>> design/ibfr_fifo.sv
// ----------------------------------------------------------------------------
// ibfr_fifo
// Small synchronous FIFO between the front end and the back end.
// ----------------------------------------------------------------------------
module ibfr_fifo #(
   parameter int WIDTH = 16,
   parameter int DEPTH = 4
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             push,
   input  logic [WIDTH-1:0] wr_data,
   input  logic             pop,
   output logic [WIDTH-1:0] rd_data,
   output logic             full,
   output logic             empty
);

   localparam int AW = $clog2(DEPTH);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [AW:0]      wr_ptr_ff, wr_ptr_in;
   logic [AW:0]      rd_ptr_ff, rd_ptr_in;

   // Status from pointer distance
   assign empty   = (wr_ptr_ff == rd_ptr_ff);
   assign full    = (wr_ptr_ff[AW-1:0] == rd_ptr_ff[AW-1:0]) &&
                    (wr_ptr_ff[AW] != rd_ptr_ff[AW]);
   assign rd_data = mem_ff[rd_ptr_ff[AW-1:0]];

   assign wr_ptr_in = wr_ptr_ff + (AW+1)'(push && !full);
   assign rd_ptr_in = rd_ptr_ff + (AW+1)'(pop && !empty);

   // Pointers
   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
      end
   end

   // Storage
   always_ff @(posedge clock) begin
      if (push && !full) begin
         mem_ff[wr_ptr_ff[AW-1:0]] <= wr_data;
      end
   end

endmodule

>>> design/ibfr_front.sv
// ----------------------------------------------------------------------------
// ibfr_front
// Front end: header hunt, byte position tracking and classification of each
// stored byte into its field and slot within the field.
// ----------------------------------------------------------------------------
module ibfr_front
   import ibfr_pkg::*;
#(
   parameter int FRAME_BYTES = 28
) (
   input  logic       clock,
   input  logic       reset,
   input  logic       csr_we,
   input  logic [7:0] csr_wdata,
   input  logic       in_valid,
   input  logic [7:0] in_byte,
   input  logic       q_full,
   output logic       in_ready,
   output logic       q_push,
   output item_type   q_item
);

   localparam int POS_W = $clog2(FRAME_BYTES);

   logic [7:0]         header_ff;
   logic [POS_W-1:0]   pos_ff, pos_in;
   logic [1:0]         slot_ff, slot_in;
   logic [FIELD_W-1:0] field_ff, field_in;
   logic               in_frame, opens, last, accept;

   assign in_ready = !q_full;
   assign accept   = in_valid && !q_full;
   assign in_frame = (pos_ff != '0);
   assign opens    = !in_frame && (in_byte == header_ff);
   assign last     = (pos_ff == POS_W'(FRAME_BYTES - 1));
   assign q_push   = accept && (in_frame || opens);

   // Classify the byte
   always_comb begin
      q_item.data  = in_byte;
      q_item.field = field_ff;
      q_item.last  = last;
      q_item.kind  = KIND_SKIP;
      if (in_frame && (field_ff != FIELD_W'(NUM_FIELDS))) begin
         case (slot_ff)
            2'd0:    q_item.kind = KIND_B0;
            2'd1:    q_item.kind = KIND_B1;
            2'd2:    q_item.kind = KIND_B2;
            default: q_item.kind = KIND_SKIP;
         endcase
      end
   end

   // Position and field counters
   always_comb begin
      pos_in   = pos_ff;
      slot_in  = slot_ff;
      field_in = field_ff;
      if (q_push) begin
         pos_in = last ? '0 : pos_ff + POS_W'(1);
         if (!in_frame) begin
            slot_in  = 2'd0;
            field_in = '0;
         end else if (field_ff != FIELD_W'(NUM_FIELDS)) begin
            if (slot_ff == 2'd2) begin
               slot_in  = 2'd0;
               field_in = field_ff + FIELD_W'(1);
            end else begin
               slot_in = slot_ff + 2'd1;
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         header_ff <= '0;
         pos_ff    <= '0;
         slot_ff   <= '0;
         field_ff  <= '0;
      end else begin
         if (csr_we) begin
            header_ff <= csr_wdata;
         end
         pos_ff   <= pos_in;
         slot_ff  <= slot_in;
         field_ff <= field_in;
      end
   end

endmodule

>>> design/ibfr_back.sv
// ----------------------------------------------------------------------------
// ibfr_back
// Back end: accumulates each sign-magnitude BCD field as its bytes arrive
// and drives the result register on the closing byte of a frame.
// ----------------------------------------------------------------------------
module ibfr_back
   import ibfr_pkg::*;
(
   input  logic             clock,
   input  logic             reset,
   input  logic             q_empty,
   input  item_type         q_item,
   output logic             q_pop,
   output logic             rsp_tvalid,
   input  logic             rsp_tready,
   output logic [RSP_W-1:0] rsp_tdata
);

   logic [MAG_W-1:0]        mag_ff, mag_in;
   logic                    neg_ff, neg_in;
   logic signed [VAL_W-1:0] res_ff [NUM_FIELDS];
   logic signed [VAL_W-1:0] res_in [NUM_FIELDS];
   logic                    rsp_valid_ff, rsp_valid_in;
   logic [RSP_W-1:0]        rsp_data_ff, rsp_data_in;
   logic [3:0]              hi, lo;
   logic [MAG_W-1:0]        total;
   logic signed [VAL_W-1:0] value;

   assign hi    = q_item.data[7:4];
   assign lo    = q_item.data[3:0];
   assign q_pop = !q_empty && (!q_item.last || !rsp_valid_ff || rsp_tready);

   // Digit weighting per slot
   always_comb begin
      mag_in = mag_ff;
      neg_in = neg_ff;
      total  = mag_ff + MAG_W'(hi) * MAG_W'(10) + MAG_W'(lo);
      value  = neg_ff ? -$signed(VAL_W'(total)) : $signed(VAL_W'(total));
      res_in = res_ff;
      if (q_pop) begin
         case (q_item.kind)
            KIND_B0: begin
               mag_in = MAG_W'(lo) * MAG_W'(10000);
               neg_in = (hi != 4'd0);
            end
            KIND_B1: begin
               mag_in = mag_ff + MAG_W'(hi) * MAG_W'(1000) + MAG_W'(lo) * MAG_W'(100);
            end
            KIND_B2: begin
               res_in[q_item.field] = value;
            end
            default: begin
               mag_in = mag_ff;
            end
         endcase
      end
   end

   // Result beat packing, roll in the lowest bits
   always_comb begin
      rsp_data_in = '0;
      for (int k = 0; k < NUM_FIELDS; k++) begin
         rsp_data_in[k*VAL_W +: VAL_W] = res_in[k];
      end
   end

   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      if (q_pop && q_item.last) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_tready) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // Payload registers
   always_ff @(posedge clock) begin
      mag_ff <= mag_in;
      neg_ff <= neg_in;
      res_ff <= res_in;
      if (q_pop && q_item.last) begin
         rsp_data_ff <= rsp_data_in;
      end
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = rsp_data_ff;

endmodule

>>> design/imu_bcd_frame_receiver.sv
// ----------------------------------------------------------------------------
// imu_bcd_frame_receiver
// Frame receiver for an IMU sending sign-magnitude BCD values.
// ----------------------------------------------------------------------------
// The block takes one received byte per beat and hunts for the header byte
// set through csr_we/csr_wdata; every other byte outside a frame is dropped.
// After the header it counts FRAME_BYTES bytes (header bytes inside a frame
// do not resync) and decodes bytes 1..27 as nine 3-byte BCD values, roll,
// pitch, yaw, accel x/y/z and rate x/y/z, each negative when the high nibble
// of its first byte is nonzero. Bytes past byte 27 are counted but ignored.
// One byte is accepted every cycle while the queue is not full. The closing
// byte's beat passes the queue and then the decode and result register
// before the result beat is valid, when no earlier result is still waiting.
// A four-entry queue between the header/position front end and the decode
// back end absorbs output stalls, so req_tready drops only once a stalled
// result and four queued bytes back up.
// ----------------------------------------------------------------------------
module imu_bcd_frame_receiver
   import ibfr_pkg::*;
#(
   parameter int FRAME_BYTES = 28
) (
   input  logic             clock,
   input  logic             reset,
   // configuration
   input  logic             csr_we,
   input  logic [7:0]       csr_wdata,   // header_byte
   // input stream
   input  logic             req_tvalid,
   output logic             req_tready,
   input  logic [7:0]       req_tdata,   // rx_byte
   // result stream
   output logic             rsp_tvalid,
   input  logic             rsp_tready,
   // roll, pitch, yaw, accel_x, accel_y, accel_z, rate_x, rate_y, rate_z
   // (19 bits each), zero pad
   output logic [RSP_W-1:0] rsp_tdata
);

   item_type front_item, back_item;
   logic     q_push, q_pop, q_full, q_empty;

   ibfr_front #(
      .FRAME_BYTES(FRAME_BYTES)
   ) u_front (
      .clock     (clock),
      .reset     (reset),
      .csr_we    (csr_we),
      .csr_wdata (csr_wdata),
      .in_valid  (req_tvalid),
      .in_byte   (req_tdata),
      .q_full    (q_full),
      .in_ready  (req_tready),
      .q_push    (q_push),
      .q_item    (front_item)
   );

   ibfr_fifo #(
      .WIDTH($bits(item_type)),
      .DEPTH(4)
   ) u_fifo (
      .clock   (clock),
      .reset   (reset),
      .push    (q_push),
      .wr_data (front_item),
      .pop     (q_pop),
      .rd_data (back_item),
      .full    (q_full),
      .empty   (q_empty)
   );

   ibfr_back u_back (
      .clock      (clock),
      .reset      (reset),
      .q_empty    (q_empty),
      .q_item     (back_item),
      .q_pop      (q_pop),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata)
   );

endmodule

>>> design/ibfr_checker.sv
// ----------------------------------------------------------------------------
// ibfr_checker
// Port-level checks of the IMU BCD frame receiver, bound to the top level.
// ----------------------------------------------------------------------------
module ibfr_checker
   import ibfr_pkg::*;
(
   input logic             clock,
   input logic             reset,
   input logic             req_tready,
   input logic             rsp_tvalid,
   input logic             rsp_tready,
   input logic [RSP_W-1:0] rsp_tdata
);

   // Every decoded value stays within a magnitude of 166665 (nibbles above 9 allowed)
   function automatic logic in_range(logic [RSP_W-1:0] d);
      logic ok;
      logic signed [VAL_W-1:0] v;
      ok = 1'b1;
      for (int k = 0; k < NUM_FIELDS; k++) begin
         v = d[k*VAL_W +: VAL_W];
         if (v > 19'sd166665 || v < -19'sd166665) begin
            ok = 1'b0;
         end
      end
      return ok;
   endfunction

   // stalled result beat holds
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tready |=> rsp_tvalid && $stable(rsp_tdata))
      else $error("result beat changed while stalled");

   // reset leaves no result pending
   a_reset_idle: assert property (@(posedge clock)
      reset |=> !rsp_tvalid)
      else $error("result valid after reset");

   // queue is empty after reset, so input is taken
   a_reset_ready: assert property (@(posedge clock)
      reset |=> req_tready)
      else $error("input not ready after reset");

   // decoded values in range, padding zero
   a_range: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid |-> in_range(rsp_tdata) &&
                     (rsp_tdata[RSP_W-1:NUM_FIELDS*VAL_W] == '0))
      else $error("decoded value out of range");

endmodule

bind imu_bcd_frame_receiver ibfr_checker u_ibfr_checker (
   .clock      (clock),
   .reset      (reset),
   .req_tready (req_tready),
   .rsp_tvalid (rsp_tvalid),
   .rsp_tready (rsp_tready),
   .rsp_tdata  (rsp_tdata)
);

>>> bench/imu_frame_checker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// imu_frame_checker
// Watches the byte, result and header-write ports of the IMU frame receiver.
// Tracks the header byte and the open frame, and decodes each completed frame
// into nine expected signed values. Every result beat is compared field by
// field with the oldest expected reading.
// ----------------------------------------------------------------------------
module imu_frame_checker
   import ibfr_pkg::*;
#(
   parameter int FRAME_BYTES = 28
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             csr_we,
   input  logic [7:0]       csr_wdata,
   input  logic             req_tvalid,
   input  logic             req_tready,
   input  logic [7:0]       req_tdata,
   input  logic             rsp_tvalid,
   input  logic             rsp_tready,
   input  logic [RSP_W-1:0] rsp_tdata,
   output int               mismatch_count,
   output int               readings_pending
);

   typedef logic [NUM_FIELDS-1:0][VAL_W-1:0] reading_t;

   reading_t    expected_readings [$];
   logic [7:0]  header_byte = 8'h00;
   int unsigned bytes_held = 0;
   logic [7:0]  frame_bytes [FRAME_BYTES];
   int          fail_total = 0;

   string field_name [NUM_FIELDS] = '{"roll", "pitch", "yaw", "accel_x", "accel_y",
                                      "accel_z", "rate_x", "rate_y", "rate_z"};

   // sign-magnitude BCD group; digits above 9 keep their raw weight
   function automatic logic [VAL_W-1:0] bcd_value(input logic [7:0] b0, input logic [7:0] b1,
                                                  input logic [7:0] b2);
      int magnitude;
      magnitude = int'(b0[3:0]) * 10000 + int'(b1[7:4]) * 1000 + int'(b1[3:0]) * 100
                + int'(b2[7:4]) * 10 + int'(b2[3:0]);
      if (b0[7:4] != 4'h0) magnitude = -magnitude;
      return magnitude[VAL_W-1:0];
   endfunction

   task automatic report(input string what);
      $display("%0t ns: mismatch: %s", $time, what);
      fail_total++;
   endtask

   // one accepted byte: hunt for the header, store, decode on the last byte
   task automatic take_byte(input logic [7:0] b);
      reading_t r;
      if (bytes_held == 0 && b != header_byte) return;
      if (bytes_held < FRAME_BYTES) frame_bytes[bytes_held] = b;
      bytes_held++;
      if (bytes_held < FRAME_BYTES) return;
      bytes_held = 0;
      for (int k = 0; k < NUM_FIELDS; k++) begin
         r[k] = bcd_value(frame_bytes[1 + 3 * k], frame_bytes[2 + 3 * k], frame_bytes[3 + 3 * k]);
      end
      expected_readings.push_back(r);
   endtask

   task automatic check_reading(input logic [RSP_W-1:0] data);
      reading_t want;
      if (expected_readings.size() == 0) begin
         report("result beat with no completed frame waiting");
         return;
      end
      want = expected_readings.pop_front();
      for (int k = 0; k < NUM_FIELDS; k++) begin
         if (data[k * VAL_W +: VAL_W] !== want[k]) begin
            report($sformatf("%s got %0d, expected %0d", field_name[k],
                             $signed(data[k * VAL_W +: VAL_W]), $signed(want[k])));
         end
      end
      if (data[RSP_W-1:NUM_FIELDS*VAL_W] !== '0) report("nonzero pad bits in result beat");
   endtask

   // results are checked before the byte of the same edge is taken
   always @(posedge clock) begin
      if (reset) begin
         header_byte = 8'h00;
         bytes_held  = 0;
         expected_readings.delete();
      end else begin
         if (rsp_tvalid && rsp_tready) check_reading(rsp_tdata);
         if (req_tvalid && req_tready) take_byte(req_tdata);
         if (csr_we) header_byte = csr_wdata;
      end
      mismatch_count   <= fail_total;
      readings_pending <= expected_readings.size();
   end

endmodule

>>> bench/testbench.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// testbench
// Stimulus and verdict for the IMU BCD frame receiver.
// A directed frame covers the value extremes, negative zero, digits above 9
// and header bytes inside a frame; then several header settings each get
// random frames mixed with noise bytes, with random gaps and result stalls in all but the last.
// ----------------------------------------------------------------------------
module testbench;
   import ibfr_pkg::*;

   localparam int FRAME_LEN    = 28;
   localparam int QUIET_LIMIT  = 1000;
   localparam int DRAIN_CYCLES = 24;
   localparam int PHASE_FRAMES = 6;
   localparam int NUM_PHASES   = 5;

   logic             clock      = 1'b0;
   logic             reset      = 1'b1;
   logic             csr_we     = 1'b0;
   logic [7:0]       csr_wdata  = 8'h00;
   logic             req_tvalid = 1'b0;
   logic             req_tready;
   logic [7:0]       req_tdata  = 8'h00;
   logic             rsp_tvalid;
   logic             rsp_tready = 1'b0;
   logic [RSP_W-1:0] rsp_tdata;

   int          mismatch_count;
   int          readings_pending;
   logic [7:0]  header      = 8'h00;
   int unsigned frame_pos   = 0;
   int          frames_sent = 0;
   bit          req_idle_on = 1'b0;
   bit          rsp_idle_on = 1'b0;
   int          stall_left  = 0;
   int          quiet_cycles = 0;

   imu_bcd_frame_receiver #(
      .FRAME_BYTES(FRAME_LEN)
   ) dut (
      .clock      (clock),
      .reset      (reset),
      .csr_we     (csr_we),
      .csr_wdata  (csr_wdata),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata)
   );

   imu_frame_checker #(
      .FRAME_BYTES(FRAME_LEN)
   ) frame_check (
      .clock            (clock),
      .reset            (reset),
      .csr_we           (csr_we),
      .csr_wdata        (csr_wdata),
      .req_tvalid       (req_tvalid),
      .req_tready       (req_tready),
      .req_tdata        (req_tdata),
      .rsp_tvalid       (rsp_tvalid),
      .rsp_tready       (rsp_tready),
      .rsp_tdata        (rsp_tdata),
      .mismatch_count   (mismatch_count),
      .readings_pending (readings_pending)
   );

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   // result side: random stall bursts
   always @(posedge clock) begin
      if (stall_left > 0) begin
         stall_left <= stall_left - 1;
         rsp_tready <= (stall_left == 1);
      end else if (rsp_idle_on && !reset && $urandom_range(0, 9) == 0) begin
         stall_left <= $urandom_range(1, 19);
         rsp_tready <= 1'b0;
      end else begin
         rsp_tready <= 1'b1;
      end
   end

   // watchdog: cycles with no beat on any port
   always @(posedge clock) begin
      if (reset || (req_tvalid && req_tready) || (rsp_tvalid && rsp_tready) || csr_we) begin
         quiet_cycles <= 0;
      end else if (quiet_cycles == QUIET_LIMIT) begin
         $display("testbench NOT OK");
         $finish;
      end else begin
         quiet_cycles <= quiet_cycles + 1;
      end
   end

   function automatic logic [7:0] frame_content();
      case ($urandom_range(0, 4))
         0, 1: return 8'($urandom);
         2: return {4'($urandom_range(0, 9)), 4'($urandom_range(0, 9))};
         3: return {($urandom_range(0, 1) != 0) ? 4'($urandom) : 4'h0,
                    4'($urandom_range(0, 9))};
         default: return header;
      endcase
   endfunction

   function automatic logic [7:0] noise_byte();
      logic [7:0] b;
      do b = 8'($urandom); while (b == header);
      return b;
   endfunction

   // one byte beat, with an optional gap before it
   task automatic send_byte(input logic [7:0] b);
      if (req_idle_on && $urandom_range(0, 5) == 0) begin
         req_tvalid <= 1'b0;
         repeat ($urandom_range(1, 19)) @(posedge clock);
      end
      req_tvalid <= 1'b1;
      req_tdata  <= b;
      do @(posedge clock); while (!req_tready);
      // keep track of the frame boundary for phase ends
      if (frame_pos != 0 || b == header) begin
         frame_pos++;
         if (frame_pos == FRAME_LEN) begin
            frame_pos = 0;
            frames_sent++;
         end
      end
   endtask

   task automatic send_frame();
      send_byte(header);
      repeat (FRAME_LEN - 1) send_byte(frame_content());
   endtask

   // all readings back, then a further drain wait
   task automatic settle();
      req_tvalid <= 1'b0;
      @(posedge clock);
      while (readings_pending != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);
   endtask

   task automatic write_header(input logic [7:0] h);
      csr_we    <= 1'b1;
      csr_wdata <= h;
      @(posedge clock);
      csr_we    <= 1'b0;
      header     = h;
   endtask

   initial begin
      logic [7:0] opening [FRAME_LEN];
      logic [7:0] phase_header [NUM_PHASES];
      int         first_frame;
      bit         last_phase;

      repeat (11) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);
      write_header(8'h00);

      // directed: noise, then extremes, negative zero, digits above 9,
      // header bytes inside the frame
      opening = '{8'h00, 8'h0F, 8'hFF, 8'hFF, 8'hFF, 8'hFF, 8'hFF, 8'hF0, 8'h00, 8'h00,
                  8'h00, 8'h00, 8'h00, 8'h09, 8'h99, 8'h99, 8'h19, 8'h99, 8'h99,
                  8'h00, 8'h00, 8'h00, 8'h80, 8'h12, 8'h34, 8'h01, 8'h23, 8'h45};
      send_byte(8'hFF);
      send_byte(8'h01);
      for (int i = 0; i < FRAME_LEN; i++) send_byte(opening[i]);

      // random phases, each under its own header byte
      phase_header = '{8'hFF, 8'h80, 8'($urandom), 8'h01, 8'h55};
      for (int p = 0; p < NUM_PHASES; p++) begin
         last_phase = (p == NUM_PHASES - 1);
         while (frame_pos != 0) send_byte(frame_content());
         rsp_idle_on = 1'b0;
         settle();
         write_header(phase_header[p]);
         first_frame = frames_sent;
         while (frames_sent - first_frame < PHASE_FRAMES) begin
            req_idle_on = !last_phase && $urandom_range(0, 3) != 0;
            rsp_idle_on = !last_phase && $urandom_range(0, 3) != 0;
            if ($urandom_range(0, 2) == 0) repeat ($urandom_range(1, 6)) send_byte(noise_byte());
            send_frame();
         end
      end

      rsp_idle_on = 1'b0;
      settle();
      if (mismatch_count == 0) begin
         $display("testbench OK");
      end else begin
         $display("testbench NOT OK");
      end
      $finish;
   end

endmodule
